// ----- design/u8d_pkg.sv -----
// Shared types and constants for the UTF-8 stream decoder.
package u8d_pkg;

  // Byte classes found by the front end.
  typedef enum logic [2:0] {
    CLS_ASCII   = 3'd0,
    CLS_LEAD2   = 3'd1,
    CLS_LEAD3   = 3'd2,
    CLS_LEAD4   = 3'd3,
    CLS_CONT    = 3'd4,
    CLS_INVALID = 3'd5
  } cls_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_LEAD  = 3'd1,
    ST_TRUNCATED = 3'd2,
    ST_BAD_CONT  = 3'd3,
    ST_INVALID   = 3'd4
  } status_t;

  // One classified byte as it sits in the queue.
  typedef struct packed {
    cls_t       cls;
    logic [6:0] value;
    logic       eot;
  } entry_t;

  localparam logic [20:0] CP_MAX   = 21'h10FFFF;
  localparam logic [20:0] SURR_LO  = 21'h00D800;
  localparam logic [20:0] SURR_HI  = 21'h00DFFF;
  localparam logic [20:0] MIN_LEN2 = 21'h000080;
  localparam logic [20:0] MIN_LEN3 = 21'h000800;
  localparam logic [20:0] MIN_LEN4 = 21'h010000;

  localparam logic [2:0] LEN2 = 3'd2;
  localparam logic [2:0] LEN3 = 3'd3;
  localparam logic [2:0] LEN4 = 3'd4;

endpackage

// ----- design/utf8_stream_decoder.sv -----
// Top level of the strict UTF-8 stream decoder.
//
//  channel  direction  tdata                                  tlast
//  s_*      in         data_byte[7:0]                         end_of_text
//  m_*      out        code_point[20:0], status[23:21]        last_result
//
// One byte is accepted per cycle while the queue is not full; a result passes
// through the queue and then the output register of the decoder.
// The decoder consumes one queued byte per cycle while its output register
// is free or being taken, so while the output is not stalled the sustained rate is one byte per cycle.
// Reset is synchronous and clears the queue, the decoder state and m_tvalid.
// A stalled output holds the decoder; input keeps flowing until the
// queue of QUEUE_DEPTH bytes is full.
module utf8_stream_decoder
  import u8d_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // code_point[20:0], status[23:21]
  output logic        m_tlast    // last_result
);

  logic   push;
  logic   pop;
  logic   full;
  logic   empty;
  entry_t push_item;
  entry_t pop_item;

  u8d_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (full),
    .empty     (empty)
  );

  u8d_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .pop_item (pop_item),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- design/u8d_front.sv -----
// Input side: accepts bytes and classifies them for the queue.
module u8d_front
  import u8d_pkg::*;
(
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // data_byte[7:0]
  input  logic       s_tlast,   // end_of_text
  input  logic       full,
  output logic       push,
  output entry_t     push_item
);

  assign s_tready = !full;
  assign push     = s_tvalid && !full;

  // Sort the byte by its leading bits and keep only its payload bits.
  always_comb begin
    push_item.eot   = s_tlast;
    push_item.value = 7'd0;
    priority if (s_tdata[7] == 1'b0) begin
      push_item.cls   = CLS_ASCII;
      push_item.value = s_tdata[6:0];
    end else if (s_tdata[7:6] == 2'b10) begin
      push_item.cls   = CLS_CONT;
      push_item.value = {1'b0, s_tdata[5:0]};
    end else if (s_tdata[7:5] == 3'b110) begin
      push_item.cls   = CLS_LEAD2;
      push_item.value = {2'b00, s_tdata[4:0]};
    end else if (s_tdata[7:4] == 4'b1110) begin
      push_item.cls   = CLS_LEAD3;
      push_item.value = {3'b000, s_tdata[3:0]};
    end else if (s_tdata[7:3] == 5'b11110) begin
      push_item.cls   = CLS_LEAD4;
      push_item.value = {4'b0000, s_tdata[2:0]};
    end else begin
      push_item.cls   = CLS_INVALID;
    end
  end

endmodule

// ----- design/u8d_queue.sv -----
// Small register queue between the front end and the decoder.
module u8d_queue
  import u8d_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_item,
  input  logic   pop,
  output entry_t pop_item,
  output logic   full,
  output logic   empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  entry_t        slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);
  assign pop_item = slots[rd_ptr];

  // Storage writes.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");

endmodule

// ----- design/u8d_back.sv -----
// Decoder: sequence state, validity checks and the output register.
module u8d_back
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  input  entry_t      pop_item,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // code_point[20:0], status[23:21]
  output logic        m_tlast    // last_result
);

  logic [20:0] partial_value;
  logic [1:0]  bytes_remaining;
  logic [2:0]  sequence_length;
  logic        continuation_bad;
  logic        dropping_rest;

  logic [20:0] partial_value_next;
  logic [1:0]  bytes_remaining_next;
  logic [2:0]  sequence_length_next;
  logic        continuation_bad_next;
  logic        dropping_rest_next;

  logic        res_valid;
  logic [20:0] res_cp;
  status_t     res_status;
  logic        res_last;

  logic        out_free;
  logic [20:0] shifted;
  logic [1:0]  rem_dec;
  logic        bad_now;
  logic        overlong;

  assign out_free = !m_tvalid || m_tready;
  assign pop      = out_free && !empty;

  assign shifted  = {partial_value[14:0], pop_item.value[5:0]};
  assign rem_dec  = bytes_remaining - 2'd1;
  assign bad_now  = continuation_bad || (pop_item.cls != CLS_CONT);
  assign overlong = ((sequence_length == LEN2) && (shifted < MIN_LEN2)) ||
                    ((sequence_length == LEN3) && (shifted < MIN_LEN3)) ||
                    ((sequence_length == LEN4) && (shifted < MIN_LEN4));

  // Step the decoder over one classified byte.
  always_comb begin
    partial_value_next    = partial_value;
    bytes_remaining_next  = bytes_remaining;
    sequence_length_next  = sequence_length;
    continuation_bad_next = continuation_bad;
    dropping_rest_next    = dropping_rest;
    res_valid             = 1'b0;
    res_cp                = '0;
    res_status            = ST_OK;
    res_last              = 1'b1;

    if (dropping_rest) begin
      // Skip to the end of the broken text.
      if (pop_item.eot) begin
        dropping_rest_next = 1'b0;
      end
    end else if (bytes_remaining == 2'd0) begin
      // Expecting a lead byte.
      res_valid = 1'b1;
      unique case (pop_item.cls)
        CLS_ASCII: begin
          res_cp   = {14'd0, pop_item.value};
          res_last = pop_item.eot;
        end
        CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
          if (pop_item.eot) begin
            res_status = ST_TRUNCATED;
          end else begin
            res_valid             = 1'b0;
            partial_value_next    = {14'd0, pop_item.value};
            continuation_bad_next = 1'b0;
            if (pop_item.cls == CLS_LEAD2) begin
              sequence_length_next = LEN2;
              bytes_remaining_next = 2'd1;
            end else if (pop_item.cls == CLS_LEAD3) begin
              sequence_length_next = LEN3;
              bytes_remaining_next = 2'd2;
            end else begin
              sequence_length_next = LEN4;
              bytes_remaining_next = 2'd3;
            end
          end
        end
        default: begin
          res_status = ST_BAD_LEAD;
        end
      endcase
    end else begin
      // Inside a sequence: gather six more bits.
      partial_value_next    = shifted;
      bytes_remaining_next  = rem_dec;
      continuation_bad_next = bad_now;
      if (rem_dec != 2'd0) begin
        if (pop_item.eot) begin
          res_valid  = 1'b1;
          res_status = ST_TRUNCATED;
        end
      end else begin
        res_valid = 1'b1;
        if (bad_now) begin
          res_status = ST_BAD_CONT;
        end else if (overlong || (shifted > CP_MAX) ||
                     ((shifted >= SURR_LO) && (shifted <= SURR_HI))) begin
          res_status = ST_INVALID;
        end else begin
          res_cp   = shifted;
          res_last = pop_item.eot;
        end
      end
    end

    // A result ends the sequence; an error before the end of the text also starts dropping.
    if (res_valid) begin
      partial_value_next    = '0;
      bytes_remaining_next  = 2'd0;
      sequence_length_next  = 3'd0;
      continuation_bad_next = 1'b0;
      if (res_status != ST_OK) begin
        dropping_rest_next = !pop_item.eot;
      end
    end
  end

  // Decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value    <= '0;
      bytes_remaining  <= '0;
      sequence_length  <= '0;
      continuation_bad <= 1'b0;
      dropping_rest    <= 1'b0;
    end else if (pop) begin
      partial_value    <= partial_value_next;
      bytes_remaining  <= bytes_remaining_next;
      sequence_length  <= sequence_length_next;
      continuation_bad <= continuation_bad_next;
      dropping_rest    <= dropping_rest_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= pop && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      m_tdata <= {res_status, res_cp};
      m_tlast <= res_last;
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && (m_tdata[23:21] != ST_OK)) |-> ((m_tdata[20:0] == '0) && m_tlast))
    else $error("error result without zero code point or last mark");
  a_len_rem: assert property (@(posedge clk) disable iff (rst)
      (bytes_remaining != 2'd0) |-> ((sequence_length > {1'b0, bytes_remaining}) &&
                                     !dropping_rest))
    else $error("sequence state inconsistent");
  a_drop_after_err: assert property (@(posedge clk) disable iff (rst)
      (pop && res_valid && (res_status != ST_OK) && !pop_item.eot) |=> dropping_rest)
    else $error("error inside a text did not start dropping");

endmodule

// ----- tb/tb_utf8_stream_decoder.sv -----
// Self-checking testbench for the UTF-8 stream decoder: directed and random texts.
`timescale 1ns / 100ps

module tb_utf8_stream_decoder
  import u8d_pkg::*;
();

  // One decoded result as the output stream carries it.
  typedef struct {
    logic [20:0] cp;
    status_t     status;
    logic        last;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // data_byte[7:0]
  logic        s_tlast;   // end_of_text
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // code_point[20:0], status[23:21]
  logic        m_tlast;   // last_result

  utf8_stream_decoder dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always #1 clk = ~clk;

  // Expected decoder results, oldest first.
  decoded_t pending_results[$];

  // Decoder state as predicted from the accepted bytes.
  logic [20:0] part_cp   = '0;
  logic [1:0]  cont_left = '0;
  logic [2:0]  seq_len   = '0;
  logic        cont_bad  = 1'b0;
  logic        drop_rest = 1'b0;

  // Bytes of the text being built for sending.
  logic [7:0] text_bytes[$];

  int unsigned bytes_sent    = 0;
  int unsigned texts_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned error_results = 0;
  int unsigned mismatches    = 0;

  // Sender burst control and receiver stall control.
  int unsigned burst_left    = 0;
  bit          gaps_on       = 1'b1;
  int unsigned hold_request  = 0;
  int unsigned hold_left     = 0;
  int unsigned rx_mode       = 0;
  int unsigned rx_phase_left = 0;
  logic [7:0]  rx_count      = '0;

  function automatic void push_result(input logic [20:0] cp, input status_t st,
                                      input logic last);
    decoded_t r;
    r.cp     = cp;
    r.status = st;
    r.last   = last;
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Adds one byte to the end of the text under construction.
  function automatic void append_byte(input logic [7:0] b);
    text_bytes.insert(text_bytes.size(), b);
  endfunction

  function automatic void clear_seq();
    part_cp   = '0;
    cont_left = '0;
    seq_len   = '0;
    cont_bad  = 1'b0;
  endfunction

  // An error drops the rest of the text unless it came on the final byte.
  function automatic void fail_text(input status_t st, input logic eot);
    clear_seq();
    drop_rest = !eot;
    push_result('0, st, 1'b1);
  endfunction

  // Advances the predicted decoder by one byte and queues any result.
  function automatic void predict_decode(input logic [7:0] b, input logic eot);
    logic [20:0] v;
    logic [2:0]  len;
    logic        bad_value;
    if (drop_rest) begin
      if (eot) drop_rest = 1'b0;
      return;
    end
    // Expecting a lead byte.
    if (cont_left == 2'd0) begin
      if (!b[7]) begin
        clear_seq();
        push_result({13'd0, b}, ST_OK, eot);
        return;
      end else if (b[7:5] == 3'b110) begin
        v = {16'd0, b[4:0]};
        len = LEN2;
      end else if (b[7:4] == 4'b1110) begin
        v = {17'd0, b[3:0]};
        len = LEN3;
      end else if (b[7:3] == 5'b11110) begin
        v = {18'd0, b[2:0]};
        len = LEN4;
      end else begin
        fail_text(ST_BAD_LEAD, eot);
        return;
      end
      if (eot) begin
        fail_text(ST_TRUNCATED, eot);
        return;
      end
      part_cp   = v;
      seq_len   = len;
      cont_left = len[1:0] - 2'd1;
      cont_bad  = 1'b0;
      return;
    end
    // Continuation byte; a bad one is only reported at the sequence end.
    if (b[7:6] != 2'b10) cont_bad = 1'b1;
    part_cp   = {part_cp[14:0], b[5:0]};
    cont_left = cont_left - 2'd1;
    if (cont_left != 2'd0) begin
      if (eot) fail_text(ST_TRUNCATED, eot);
      return;
    end
    if (cont_bad) begin
      fail_text(ST_BAD_CONT, eot);
      return;
    end
    bad_value = (seq_len == LEN2 && part_cp < MIN_LEN2) ||
                (seq_len == LEN3 && part_cp < MIN_LEN3) ||
                (seq_len == LEN4 && part_cp < MIN_LEN4) ||
                part_cp > CP_MAX ||
                (part_cp >= SURR_LO && part_cp <= SURR_HI);
    if (bad_value) begin
      fail_text(ST_INVALID, eot);
    end else begin
      push_result(part_cp, ST_OK, eot);
      clear_seq();
    end
  endfunction

  // Appends v encoded in len bytes; the length may be longer than needed.
  function automatic void add_encoded(input logic [20:0] v, input int unsigned len);
    case (len)
      1: append_byte({1'b0, v[6:0]});
      2: begin
        append_byte({3'b110, v[10:6]});
        append_byte({2'b10, v[5:0]});
      end
      3: begin
        append_byte({4'b1110, v[15:12]});
        append_byte({2'b10, v[11:6]});
        append_byte({2'b10, v[5:0]});
      end
      default: begin
        append_byte({5'b11110, v[20:18]});
        append_byte({2'b10, v[17:12]});
        append_byte({2'b10, v[11:6]});
        append_byte({2'b10, v[5:0]});
      end
    endcase
  endfunction

  // A scalar value that fits len bytes in shortest form, often at a boundary.
  function automatic logic [20:0] random_scalar(input int unsigned len);
    logic [20:0] lo;
    logic [20:0] hi;
    logic [20:0] v;
    int unsigned pick;
    case (len)
      1: begin lo = 21'h0;      hi = 21'h7F;     end
      2: begin lo = MIN_LEN2;   hi = 21'h7FF;    end
      3: begin lo = MIN_LEN3;   hi = 21'hFFFF;   end
      default: begin lo = MIN_LEN4; hi = CP_MAX; end
    endcase
    pick = $urandom_range(0, 7);
    if (pick == 0) v = lo;
    else if (pick == 1) v = hi;
    else if (pick == 2 && len == 3) v = SURR_LO - 21'd1;
    else if (pick == 3 && len == 3) v = SURR_HI + 21'd1;
    else v = 21'($urandom_range(hi, lo));
    // Move a surrogate down into the plain range below it.
    if (v >= SURR_LO && v <= SURR_HI) v[12] = 1'b0;
    return v;
  endfunction

  // A byte that is not of the form 10xxxxxx.
  function automatic logic [7:0] non_cont_byte();
    logic [7:0] b;
    int unsigned idx;
    b = 8'($urandom_range(0, 255));
    if (b[7:6] == 2'b10) begin
      idx = $urandom_range(0, 2);
      b[7:6] = (idx == 0) ? 2'b00 : (idx == 1) ? 2'b01 : 2'b11;
    end
    return b;
  endfunction

  // Builds a text of a few code points, mostly well formed.
  task automatic build_random_text();
    int unsigned n;
    int unsigned kind;
    int unsigned len;
    int unsigned base;
    int unsigned k;
    text_bytes.delete();
    if ($urandom_range(0, 99) < 6) begin
      // Pure noise.
      n = $urandom_range(1, 8);
      repeat (n) append_byte(8'($urandom_range(0, 255)));
      return;
    end
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      len  = $urandom_range(2, 4);
      base = text_bytes.size();
      if (kind < 80) begin
        len = $urandom_range(1, 4);
        add_encoded(random_scalar(len), len);
      end else if (kind < 84) begin
        if ($urandom_range(0, 1)) append_byte({2'b10, 6'($urandom_range(0, 63))});
        else append_byte({5'b11111, 3'($urandom_range(0, 7))});
      end else if (kind < 88) begin
        add_encoded(random_scalar(len), len);
        text_bytes[base + $urandom_range(1, len - 1)] = non_cont_byte();
      end else if (kind < 91) begin
        // Overlong form.
        case (len)
          2: add_encoded(21'($urandom_range(21'h7F, 0)), len);
          3: add_encoded(21'($urandom_range(21'h7FF, 0)), len);
          default: add_encoded(21'($urandom_range(21'hFFFF, 0)), len);
        endcase
      end else if (kind < 94) begin
        add_encoded(21'($urandom_range(SURR_HI, SURR_LO)), 3);
      end else if (kind < 96) begin
        add_encoded(21'($urandom_range(21'h1FFFFF, 21'h110000)), 4);
      end else if (kind < 98) begin
        // The text ends inside a sequence, sometimes after a bad continuation.
        add_encoded(random_scalar(len), len);
        k = $urandom_range(1, len - 1);
        repeat (k) void'(text_bytes.pop_back());
        if (len - k >= 2 && $urandom_range(0, 1))
          text_bytes[text_bytes.size() - 1] = non_cont_byte();
        i = n;
      end else begin
        append_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Offers one item and waits until it is taken.
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        gap = $urandom_range(1, 6);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eot;
    do @(posedge clk); while (!s_tready);
    predict_decode(b, eot);
    bytes_sent++;
  endtask

  // Sends the built text with the end flag on its final byte.
  task automatic send_text();
    for (int i = 0; i < text_bytes.size(); i++)
      send_byte(text_bytes[i], i == text_bytes.size() - 1);
    texts_sent++;
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Plain ASCII at both ends, then the shortest 2-byte and largest 4-byte values.
  task automatic test_ascii_and_multibyte();
    text_bytes = '{8'h00, 8'h7F};
    send_text();
    text_bytes = '{8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_text();
    wait_drain();
  endtask

  // A stray continuation drops the rest; an invalid lead on the final byte does not.
  task automatic test_bad_lead();
    text_bytes = '{8'h80, 8'h41, 8'hFF};
    send_text();
    text_bytes = '{8'hF8};
    send_text();
    wait_drain();
  endtask

  // Texts ending mid-sequence, one of them with a bad continuation as its final byte.
  task automatic test_truncation();
    text_bytes = '{8'hE2, 8'h82};
    send_text();
    text_bytes = '{8'hE2, 8'h41};
    send_text();
    wait_drain();
  endtask

  task automatic test_bad_continuation();
    text_bytes = '{8'hC3, 8'h41, 8'h00};
    send_text();
    wait_drain();
  endtask

  // Overlong form, surrogate and value above the largest scalar.
  task automatic test_invalid_code_point();
    text_bytes = '{8'hC0, 8'h80};
    send_text();
    text_bytes = '{8'hED, 8'hA0, 8'h80};
    send_text();
    text_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
    send_text();
    wait_drain();
  endtask

  // The receiver holds off while the sender keeps offering bytes.
  task automatic test_backpressure();
    int unsigned start;
    start = bytes_sent;
    gaps_on = 1'b0;
    hold_request = 150;
    while (bytes_sent - start < 60) begin
      build_random_text();
      send_text();
    end
    gaps_on = 1'b1;
    wait_drain();
  endtask

  task automatic test_random_texts();
    while (bytes_sent < 1250) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      build_random_text();
      send_text();
    end
    gaps_on = 1'b1;
    wait_drain();
  endtask

  // Result checker and receiver stall pattern.
  initial begin : receiver
    decoded_t want;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        results_seen++;
        if (m_tdata[23:21] != ST_OK) error_results++;
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: tdata=%h tlast=%b", m_tdata, m_tlast);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[20:0] !== want.cp) begin
            $error("code_point: expected %h, actual %h", want.cp, m_tdata[20:0]);
            mismatches++;
          end
          if (m_tdata[23:21] !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_tdata[23:21]);
            mismatches++;
          end
          if (m_tlast !== want.last) begin
            $error("last_result: expected %b, actual %b", want.last, m_tlast);
            mismatches++;
          end
        end
      end
      // Choose the ready level for the next cycle.
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (rx_phase_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_phase_left = $urandom_range(16, 160);
      end
      rx_phase_left--;
      rx_count++;
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 7) != 0);
          default: m_tready <= (rx_count[2:0] != 3'd5) && (rx_count[3:0] != 4'd2);
        endcase
      end
    end
  end

  // Main sequence.
  initial begin
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_ascii_and_multibyte();
    test_bad_lead();
    test_truncation();
    test_bad_continuation();
    test_invalid_code_point();
    test_backpressure();
    test_random_texts();
    $display("Sent %0d bytes in %0d texts, with bursts, output stalls and one long hold-off.",
             bytes_sent, texts_sent);
    $display("Checked %0d results, %0d of them error reports.", results_seen, error_results);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- files.f -----
design/u8d_pkg.sv
design/u8d_front.sv
design/u8d_queue.sv
design/u8d_back.sv
design/utf8_stream_decoder.sv
tb/tb_utf8_stream_decoder.sv
